### design/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the protected bus access block: memory
// geometry, device register map, access kinds, fault codes and control types.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int RAM_BYTES  = 65536;
    localparam int PAGE_BYTES = 256;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int CFG_W      = 8;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int CMP_W      = (PAGE_W > CFG_W) ? PAGE_W : CFG_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ADDR_W-1:0] MMIO_BASE     = 16'hF000;
    localparam logic [ADDR_W-1:0] MMIO_STATUS   = 16'hF000;
    localparam logic [ADDR_W-1:0] MMIO_DATA     = 16'hF002;
    localparam logic [ADDR_W-1:0] MMIO_DOORBELL = 16'hF004;

    localparam logic [ADDR_W:0] RAM_LIMIT = (ADDR_W+1)'(RAM_BYTES);
    localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_BYTES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_LAST   = 2'd2;

    localparam logic [CFG_W-1:0] KERNEL_LAST_RST = 8'd15;
    localparam logic [CFG_W-1:0] USER_FIRST_RST  = 8'd16;
    localparam logic [CFG_W-1:0] USER_LAST_RST   = 8'd223;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_EXEC  = 2'd2,
        KIND_DMA   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_PROT = 2'd1,
        FAULT_MMIO = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_ACCESS = 2'd2
    } state_t;

    // Outcome of one access as decoded from the held request
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        fault_t            fault;
        logic              exec_allowed;
        logic              device_irq;
        logic              ram_we;
        logic              dev_we;
    } pba_act_t;

endpackage

### design/pba_req_if.sv
// ----------------------------------------------------------------------------
// pba_req_if
// Request channel: one byte bus access with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_req_if;
    logic                          valid;
    logic                          ready;
    pba_pkg::kind_t                kind;
    logic [pba_pkg::ADDR_W-1:0]    address;
    logic [pba_pkg::DATA_W-1:0]    write_data;
    logic                          user_mode;

    modport source (output valid, kind, address, write_data, user_mode, input ready);
    modport sink   (input valid, kind, address, write_data, user_mode, output ready);
endinterface

### design/pba_rsp_if.sv
// ----------------------------------------------------------------------------
// pba_rsp_if
// Result channel: outcome of one access with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::DATA_W-1:0]    read_data;
    pba_pkg::fault_t               fault;
    logic                          exec_allowed;
    logic                          device_irq;

    modport source (output valid, read_data, fault, exec_allowed, device_irq, input ready);
    modport sink   (input valid, read_data, fault, exec_allowed, device_irq, output ready);
endinterface

### design/pba_cfg_if.sv
// ----------------------------------------------------------------------------
// pba_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pba_pkg::CFG_IDX_W-1:0]   index;
    logic [pba_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/pba_decode.sv
// ----------------------------------------------------------------------------
// pba_decode
// Permission check and device register decode for one held access.
// ----------------------------------------------------------------------------
module pba_decode (
    input  pba_pkg::kind_t                kind,
    input  logic [pba_pkg::ADDR_W-1:0]    address,
    input  logic                          user_mode,
    input  logic [pba_pkg::CFG_W-1:0]     kernel_last,
    input  logic [pba_pkg::CFG_W-1:0]     user_first,
    input  logic [pba_pkg::CFG_W-1:0]     user_last,
    input  logic                          dev_ready,
    input  logic [pba_pkg::DATA_W-1:0]    dev_data,
    input  logic [pba_pkg::DATA_W-1:0]    ram_rdata,
    output pba_pkg::pba_act_t             act
);
    import pba_pkg::*;

    logic              in_ram;
    logic [CMP_W-1:0]  page;
    logic              user_page;
    logic              allowed;

    assign in_ram    = (address < MMIO_BASE) && ({1'b0, address} < RAM_LIMIT);
    assign page      = CMP_W'(address[ADDR_W-1:PAGE_SHIFT]);
    assign user_page = (page >= CMP_W'(user_first)) && (page <= CMP_W'(user_last));
    assign allowed   = in_ram && (user_page || ((page <= CMP_W'(kernel_last)) && !user_mode));

    always_comb
    begin
        act = '0;
        act.fault = FAULT_NONE;
        case (kind)
            KIND_EXEC:
            begin
                act.exec_allowed = allowed;
            end
            KIND_DMA:
            begin
                if (in_ram)
                    act.ram_we = 1'b1;
                else
                    act.fault = FAULT_PROT;
            end
            default:
            begin
                if (address >= MMIO_BASE)
                begin
                    if (user_mode)
                        act.fault = FAULT_PROT;
                    else if (kind == KIND_READ)
                    begin
                        if (address == MMIO_STATUS)
                            act.read_data = DATA_W'(dev_ready);
                        else if (address == MMIO_DATA)
                            act.read_data = dev_data;
                        else
                            act.fault = FAULT_MMIO;
                    end
                    else if (address == MMIO_DOORBELL)
                    begin
                        act.dev_we     = 1'b1;
                        act.device_irq = 1'b1;
                    end
                    else
                        act.fault = FAULT_MMIO;
                end
                else if (!allowed)
                    act.fault = FAULT_PROT;
                else if (kind == KIND_READ)
                    act.read_data = ram_rdata;
                else
                    act.ram_we = 1'b1;
            end
        endcase
    end

endmodule

### design/protected_bus_access.sv
// ----------------------------------------------------------------------------
// protected_bus_access
// Memory protection unit in front of byte RAM and a small mapped device.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one byte access per request (read, write, execute check, DMA
//          write) with address, write byte and user-mode flag.
//   rsp  - one result per request: read byte, fault code, execute flag and
//          doorbell interrupt pulse.
//   cfg  - page bound registers, written whenever cfg.valid is high
//          (cfg.ready is always high); write only while no request is open.
// Timing: a request accepted in the idle state is read from RAM and captured
//   at acceptance; its result is registered when the access state commits,
//   which waits while a stalled result is held. No new request is taken until
//   the last one is committed, set by the two-state sequencer: read in the
//   idle state, write back in the access state before the next read is issued.
// Reset: device status and data clear, bound registers take their defaults,
//   then a clearing pass zeroes all RAM_BYTES RAM entries with req.ready
//   low. Configuration writes are taken during the pass.
// Stall: the result register holds while rsp.ready is low; one more request
//   is accepted meanwhile and waits in the access stage until the result
//   register frees up.
// ----------------------------------------------------------------------------
module protected_bus_access (
    input  logic       clk,
    input  logic       rst_n,
    pba_req_if.sink    req,
    pba_rsp_if.source  rsp,
    pba_cfg_if.sink    cfg
);
    import pba_pkg::*;

    // Sequencer state
    state_t            state_reg, state_next;
    logic [RAM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Held request
    kind_t             kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              user_reg;

    // Page bounds and device registers
    logic [CFG_W-1:0]  kernel_last_reg, user_first_reg, user_last_reg;
    logic              dev_ready_reg;
    logic [DATA_W-1:0] dev_data_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_rdata_reg;
    fault_t            out_fault_reg;
    logic              out_exec_reg;
    logic              out_irq_reg;

    // Control
    logic              accept;
    logic              load_out;
    logic              ram_re;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    pba_act_t          act;

    // Next state: clear pass, then alternate between taking a request and
    // finishing it.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RAM_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req.ready = 1'b0;
        load_out  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg[RAM_AW-1:0];
        ram_wdata = wdata_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_re    = req.valid;
            end
            ST_ACCESS:
            begin
                // Commit only when the result can be registered
                load_out = !out_valid_reg || rsp.ready;
                ram_we   = load_out && act.ram_we;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Capture the request alongside the RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            addr_reg  <= req.address;
            wdata_reg <= req.write_data;
            user_reg  <= req.user_mode;
        end
    end

    // Page bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_last_reg <= KERNEL_LAST_RST;
            user_first_reg  <= USER_FIRST_RST;
            user_last_reg   <= USER_LAST_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_KERNEL_LAST: kernel_last_reg <= cfg.data;
                CFG_USER_FIRST:  user_first_reg  <= cfg.data;
                CFG_USER_LAST:   user_last_reg   <= cfg.data;
                default:         kernel_last_reg <= kernel_last_reg;
            endcase
        end
    end

    // Doorbell: store the byte and flag it ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_ready_reg <= 1'b0;
            dev_data_reg  <= '0;
        end
        else if (load_out && act.dev_we)
        begin
            dev_ready_reg <= 1'b1;
            dev_data_reg  <= wdata_reg;
        end
    end

    pba_ram #(
        .ADDR_W (RAM_AW),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (req.address[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    pba_decode u_decode (
        .kind        (kind_reg),
        .address     (addr_reg),
        .user_mode   (user_reg),
        .kernel_last (kernel_last_reg),
        .user_first  (user_first_reg),
        .user_last   (user_last_reg),
        .dev_ready   (dev_ready_reg),
        .dev_data    (dev_data_reg),
        .ram_rdata   (ram_rdata),
        .act         (act)
    );

    // Result register: hold while the receiver stalls
    always_comb
    begin
        out_valid_next = (out_valid_reg && !rsp.ready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_rdata_reg <= act.read_data;
            out_fault_reg <= act.fault;
            out_exec_reg  <= act.exec_allowed;
            out_irq_reg   <= act.device_irq;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_rdata_reg;
    assign rsp.fault        = out_fault_reg;
    assign rsp.exec_allowed = out_exec_reg;
    assign rsp.device_irq   = out_irq_reg;

endmodule

### design/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the protected bus access block, bound to the top.
// ----------------------------------------------------------------------------
module pba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [pba_pkg::DATA_W-1:0]  rsp_read_data,
    input  pba_pkg::fault_t             rsp_fault,
    input  logic                        rsp_exec_allowed,
    input  logic                        rsp_device_irq
);
    import pba_pkg::*;

    // One request in the access stage at a time
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault)
            && $stable(rsp_read_data))
        else $error("stalled result changed");

    // Doorbell interrupt only on a clean access that returns no data
    a_irq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_device_irq |-> rsp_fault == FAULT_NONE && rsp_read_data == '0
            && !rsp_exec_allowed)
        else $error("interrupt with fault or data");

    // An allowed execute check never faults and returns no data
    a_exec_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_exec_allowed |-> rsp_fault == FAULT_NONE && rsp_read_data == '0)
        else $error("execute flag with fault or data");

endmodule

bind protected_bus_access pba_checker u_pba_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_read_data    (rsp.read_data),
    .rsp_fault        (rsp.fault),
    .rsp_exec_allowed (rsp.exec_allowed),
    .rsp_device_irq   (rsp.device_irq)
);

### verif/protected_bus_access_tb.sv
// ----------------------------------------------------------------------------
// protected_bus_access_tb
// Self-checking bench for the protected bus access block. Bus requests are
// fed from a backlog queue by a clocked driver. Each accepted request is
// scored against a shadow of the page bounds, RAM and device registers, and
// the outcome is queued. A clocked monitor compares every result with the
// oldest queued outcome. Phases step through several page-bound settings and
// three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module protected_bus_access_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int PHASES         = 8;
    localparam int RANDOM_PER_PH  = 135;
    localparam int WATCHDOG_LIMIT = 200000;  // covers the RAM clearing pass after reset
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              user_mode;
    } bus_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        fault_t            fault;
        logic              exec_allowed;
        logic              device_irq;
    } access_result_t;

    logic clk;
    logic rst_n;

    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();
    pba_cfg_if cfg_ch ();

    protected_bus_access DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow state of the protection unit
    logic [DATA_W-1:0] shadow_ram [RAM_BYTES];
    logic              dev_ready_sh;
    logic [DATA_W-1:0] dev_data_sh;
    logic [CFG_W-1:0]  kernel_last_sh;
    logic [CFG_W-1:0]  user_first_sh;
    logic [CFG_W-1:0]  user_last_sh;

    bus_req_t       access_backlog [$];   // requests not yet offered to the block
    access_result_t awaited_results [$];  // outcomes of accepted requests, oldest first

    int  sent_total;
    int  done_total;
    int  error_count;
    int  stall_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;

    // Handshake flags as seen at the last rising edge
    bit  req_taken;
    bit  rsp_taken;
    bit  cfg_taken;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow model of the protection unit
    // ------------------------------------------------------------------------

    // True when the RAM address may be touched at the given privilege.
    // The user range wins over the supervisor range where they overlap.
    function automatic bit ram_permits(logic [ADDR_W-1:0] addr, logic user);
        int pg;
        if (addr >= MMIO_BASE || int'(addr) >= RAM_BYTES)
            return 1'b0;
        pg = int'(addr) >> PAGE_SHIFT;
        if (pg >= int'(user_first_sh) && pg <= int'(user_last_sh))
            return 1'b1;
        if (pg <= int'(kernel_last_sh))
            return !user;
        return 1'b0;
    endfunction

    // Score one accepted request and advance the shadow state.
    function automatic access_result_t mpu_outcome(bus_req_t r);
        access_result_t o;
        o.read_data    = '0;
        o.fault        = FAULT_NONE;
        o.exec_allowed = 1'b0;
        o.device_irq   = 1'b0;
        if (r.kind == KIND_EXEC) begin
            // execute check only reports a flag, never faults
            o.exec_allowed = ram_permits(r.address, r.user_mode);
        end
        else if (r.kind == KIND_DMA) begin
            // DMA skips the page check; only normal RAM is reachable
            if (r.address >= MMIO_BASE || int'(r.address) >= RAM_BYTES)
                o.fault = FAULT_PROT;
            else
                shadow_ram[r.address] = r.write_data;
        end
        else if (r.address >= MMIO_BASE) begin
            if (r.user_mode)
                o.fault = FAULT_PROT;
            else if (r.kind == KIND_READ) begin
                if (r.address == MMIO_STATUS)
                    o.read_data = DATA_W'(dev_ready_sh);
                else if (r.address == MMIO_DATA)
                    o.read_data = dev_data_sh;
                else
                    o.fault = FAULT_MMIO;
            end
            else if (r.address == MMIO_DOORBELL) begin
                dev_ready_sh = 1'b1;
                dev_data_sh  = r.write_data;
                o.device_irq = 1'b1;
            end
            else
                o.fault = FAULT_MMIO;
        end
        else if (!ram_permits(r.address, r.user_mode))
            o.fault = FAULT_PROT;
        else if (r.kind == KIND_READ)
            o.read_data = shadow_ram[r.address];
        else
            shadow_ram[r.address] = r.write_data;
        return o;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample handshakes at the rising edge, score requests, check
    // results, track page-bound writes and watch for a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        access_result_t want;
        bus_req_t       seen;
        req_taken = rst_n && req_ch.valid && req_ch.ready;
        rsp_taken = rst_n && rsp_ch.valid && rsp_ch.ready;
        cfg_taken = rst_n && cfg_ch.valid && cfg_ch.ready;

        if (cfg_taken) begin
            case (cfg_ch.index)
                CFG_KERNEL_LAST: kernel_last_sh = cfg_ch.data;
                CFG_USER_FIRST:  user_first_sh  = cfg_ch.data;
                CFG_USER_LAST:   user_last_sh   = cfg_ch.data;
                default: ;
            endcase
        end

        if (req_taken) begin
            seen.kind       = req_ch.kind;
            seen.address    = req_ch.address;
            seen.write_data = req_ch.write_data;
            seen.user_mode  = req_ch.user_mode;
            awaited_results.insert(awaited_results.size(), mpu_outcome(seen));
        end

        if (rsp_taken) begin
            done_total++;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with no request outstanding, actual rd=%0h fault=%0d",
                         $time, rsp_ch.read_data, int'(rsp_ch.fault));
                error_count++;
            end
            else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                compare_field("read_data", want.read_data, rsp_ch.read_data);
                compare_field("fault", int'(want.fault), int'(rsp_ch.fault));
                compare_field("exec_allowed", want.exec_allowed, rsp_ch.exec_allowed);
                compare_field("device_irq", want.device_irq, rsp_ch.device_irq);
            end
        end

        // Count cycles with no progress on any channel
        if (req_taken || rsp_taken || cfg_taken)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("protected_bus_access_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold a request until it is
    // taken, then advance to the next one or idle at random.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        bus_req_t nxt;
        if (rst_n && (!req_ch.valid || req_taken)) begin
            if (access_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = access_backlog[0];
                access_backlog.delete(0);
                req_ch.valid      <= 1'b1;
                req_ch.kind       <= nxt.kind;
                req_ch.address    <= nxt.address;
                req_ch.write_data <= nxt.write_data;
                req_ch.user_mode  <= nxt.user_mode;
            end
            else
                req_ch.valid <= 1'b0;
        end
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_access(kind_t k, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] wd, logic user);
        bus_req_t r;
        r.kind       = k;
        r.address    = addr;
        r.write_data = wd;
        r.user_mode  = user;
        access_backlog.insert(access_backlog.size(), r);
        sent_total++;
    endtask

    // Mostly addresses near the current page bounds and the device map, so
    // that writes are read back and every permission edge is crossed; the
    // rest lands anywhere.
    function automatic bus_req_t random_access();
        bus_req_t         r;
        int               sel;
        logic [CFG_W-1:0] pg;
        sel          = $urandom_range(99);
        r.kind       = kind_t'($urandom_range(3));
        r.write_data = DATA_W'($urandom);
        r.user_mode  = 1'($urandom);
        if (sel < 50) begin
            case ($urandom_range(6))
                0: pg = kernel_last_sh;
                1: pg = kernel_last_sh + 1'b1;
                2: pg = user_first_sh;
                3: pg = user_first_sh - 1'b1;
                4: pg = user_last_sh;
                5: pg = user_last_sh + 1'b1;
                default: pg = CFG_W'($urandom);
            endcase
            r.address = ADDR_W'(int'(pg) << PAGE_SHIFT)
                      + ADDR_W'($urandom_range(3) * ($urandom_range(1) ? 1 : PAGE_BYTES / 4));
        end
        else if (sel < 72) begin
            // device registers, mostly from supervisor mode
            r.address   = MMIO_BASE + ADDR_W'($urandom_range(7));
            r.user_mode = ($urandom_range(3) == 0);
        end
        else if (sel < 80)
            r.address = MMIO_BASE | ADDR_W'($urandom_range(16'h0FFF));
        else
            r.address = ADDR_W'($urandom);
        return r;
    endfunction

    // Write one page-bound register; call at a falling edge, returns at the
    // falling edge after it is taken with valid still high.
    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(negedge clk); while (!cfg_taken);
    endtask

    task automatic program_bounds(logic [CFG_W-1:0] kl, logic [CFG_W-1:0] uf,
                                  logic [CFG_W-1:0] ul);
        write_bound(CFG_KERNEL_LAST, kl);
        write_bound(CFG_USER_FIRST, uf);
        write_bound(CFG_USER_LAST, ul);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every request sent so far has produced its result
    task automatic drain_results();
        while (done_total != sent_total)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        int n;

        clk   = 1'b0;
        rst_n = 1'b0;
        foreach (shadow_ram[i])
            shadow_ram[i] = '0;
        dev_ready_sh   = 1'b0;
        dev_data_sh    = '0;
        kernel_last_sh = KERNEL_LAST_RST;
        user_first_sh  = USER_FIRST_RST;
        user_last_sh   = USER_LAST_RST;

        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_READ;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        req_ch.user_mode  = 1'b0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_KERNEL_LAST;
        cfg_ch.data       = '0;

        sent_total    = 0;
        done_total    = 0;
        error_count   = 0;
        stall_cycles  = 0;
        send_idle_pct = 15;
        recv_idle_pct = 72;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++) begin
            // swap the idling mix, then drop idling altogether
            if (ph == 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 15;
            end
            else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (ph)
                0: ;  // reset bounds
                1: program_bounds(8'd0, 8'd0, 8'd0);
                2: program_bounds(8'd239, 8'd239, 8'd239);
                3: program_bounds(8'd239, 8'd0, 8'd239);  // user range covers all
                4: program_bounds(8'd100, 8'd200, 8'd50); // empty user range
                6: program_bounds(8'd0, 8'd239, 8'd0);
                default: program_bounds(CFG_W'($urandom_range(239)),
                                        CFG_W'($urandom_range(239)),
                                        CFG_W'($urandom_range(239)));
            endcase

            if (ph == 0) begin
                // user and supervisor pages, unmapped pages
                queue_access(KIND_WRITE, 16'h1000, 8'hA5, 1'b1);
                queue_access(KIND_READ,  16'h1000, 8'h00, 1'b1);
                queue_access(KIND_READ,  16'h0000, 8'h00, 1'b0);
                queue_access(KIND_WRITE, 16'h0FFF, 8'hFF, 1'b0);
                queue_access(KIND_READ,  16'h0FFF, 8'h00, 1'b1);
                queue_access(KIND_READ,  16'hE000, 8'h00, 1'b0);
                queue_access(KIND_WRITE, 16'hEFFF, 8'h5A, 1'b0);
                queue_access(KIND_READ,  16'hDFFF, 8'h00, 1'b1);
                // execute checks, including device and supervisor pages
                queue_access(KIND_EXEC,  16'h0000, 8'h00, 1'b1);
                queue_access(KIND_EXEC,  16'h0FFF, 8'h00, 1'b0);
                queue_access(KIND_EXEC,  16'hDFFF, 8'h00, 1'b1);
                queue_access(KIND_EXEC,  MMIO_DOORBELL, 8'h00, 1'b0);
                // device map: status before and after the doorbell
                queue_access(KIND_READ,  MMIO_STATUS, 8'h00, 1'b0);
                queue_access(KIND_WRITE, MMIO_DOORBELL, 8'h5A, 1'b0);
                queue_access(KIND_READ,  MMIO_STATUS, 8'h00, 1'b0);
                queue_access(KIND_READ,  MMIO_DATA, 8'h00, 1'b0);
                queue_access(KIND_READ,  MMIO_STATUS, 8'h00, 1'b1);
                queue_access(KIND_WRITE, MMIO_DOORBELL, 8'hFF, 1'b1);
                queue_access(KIND_READ,  16'hF001, 8'h00, 1'b0);
                queue_access(KIND_WRITE, MMIO_STATUS, 8'h11, 1'b0);
                queue_access(KIND_READ,  16'hFFFF, 8'h00, 1'b0);
                // DMA ignores pages but not the device window
                queue_access(KIND_DMA,   16'h0000, 8'h3C, 1'b1);
                queue_access(KIND_DMA,   16'hE123, 8'hC3, 1'b0);
                queue_access(KIND_DMA,   16'hFFFF, 8'h77, 1'b0);
                queue_access(KIND_READ,  16'h0000, 8'h00, 1'b0);
            end

            for (n = 0; n < RANDOM_PER_PH; n++) begin
                access_backlog.insert(access_backlog.size(), random_access());
                sent_total++;
            end

            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("protected_bus_access_tb: clean");
        else
            $display("protected_bus_access_tb: errors");
        $finish;
    end

endmodule
